>>> design/scope_trace_column_render_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trace column renderer
// Wrap concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCOPE_TRACE_COLUMN_RENDER_MACROS_SVH
`define SCOPE_TRACE_COLUMN_RENDER_MACROS_SVH

// same-cycle implication
`define SCTR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define SCTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> design/sctr_pkg.sv
// ----------------------------------------------------------------------------
// sctr_pkg
// Geometry, field widths and shared types of the trace column renderer.
// ----------------------------------------------------------------------------
package sctr_pkg;

	localparam int COLUMNS   = 127;
	localparam int PAGES     = 7;

	localparam int SAMPLE_W  = 6;
	localparam int COL_W     = 7;
	localparam int PAGE_W    = 3;
	localparam int BYTE_W    = 8;

	localparam int CNT_W     = $clog2(COLUMNS);
	localparam int IDX_W     = $clog2(PAGES + 1);
	localparam int VAL_W     = 7;
	localparam int TOP_ROW   = 8 * PAGES - 1;
	localparam int MID_ROW   = (TOP_ROW + 1) / 2;
	localparam int PAGE_LAST = PAGES - 1;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COL_W-1:0]    column_t;
	typedef logic [PAGE_W-1:0]   page_t;
	typedef logic [BYTE_W-1:0]   pixbyte_t;
	typedef logic [VAL_W-1:0]    val_t;

	typedef struct packed {
		logic en;
		val_t lo;
		val_t hi;
	} run_t;

endpackage

>>> design/sctr_if.sv
// ----------------------------------------------------------------------------
// sctr_if
// Valid/ready channels: trace samples in, page pixel beats out.
// ----------------------------------------------------------------------------
interface sctr_trace_if import sctr_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface sctr_pixel_if import sctr_pkg::*; ();
	logic     valid;
	logic     ready;
	column_t  column;
	page_t    page;
	pixbyte_t pixel_byte;
	logic     last;

	modport source (output valid, output column, output page, output pixel_byte,
		output last, input ready);
	modport sink   (input valid, input column, input page, input pixel_byte,
		input last, output ready);
endinterface

>>> design/scope_trace_column_render.sv
// ----------------------------------------------------------------------------
// scope_trace_column_render
// Turns one trace sample per screen column into page pixel bytes.
//
//   channel | dir | payload                          | beats per sample
//   trace   | in  | sample                           | 1
//   pixels  | out | column, page, pixel_byte, last   | 0, 1, 7 or 8
//
// A sample is registered with its run or dot in the job register, then one
// pixel beat per cycle, unless the output stalls, leaves from the job register
// through the output register.
// The next sample is taken in the cycle the current job's last beat moves out.
// Reset clears the column counter, the sample history and all valid flags.
// ----------------------------------------------------------------------------
module scope_trace_column_render import sctr_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	sctr_trace_if.sink   trace,
	sctr_pixel_if.source pixels
);

	logic [CNT_W-1:0] cnt_q;
	sample_t          older_q;
	sample_t          middle_q;

	logic             job_valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             has_inner_s1;
	logic             has_dot_s1;
	logic [CNT_W-1:0] cnt_s1;
	run_t             run_s1;
	page_t            dot_page_s1;
	pixbyte_t         dot_byte_s1;

	logic             out_valid_q;
	column_t          column_q;
	page_t            page_q;
	pixbyte_t         byte_q;
	logic             last_q;

	logic             in_acc;
	logic             first_col;
	logic             last_col;
	logic             has_inner;
	logic             has_res;
	run_t             run_d;
	page_t            dot_page_d;
	pixbyte_t         dot_byte_d;

	logic             inner_sel;
	logic             advance;
	column_t          cur_column;
	page_t            cur_page;
	pixbyte_t         cur_byte;
	logic             cur_last;
	pixbyte_t         page_bits;

	assign in_acc    = trace.valid && trace.ready;
	assign first_col = (cnt_q == '0);
	assign last_col  = (cnt_q == CNT_W'(COLUMNS - 1));
	assign has_inner = (cnt_q >= CNT_W'(2));
	assign has_res   = first_col || has_inner;

	// run of rows for the inner column (older, middle, new sample)
	always_comb begin
		val_t prev, cur, next;
		val_t lo, md, hi, srt, fin, t;
		t    = '0;
		prev = VAL_W'(older_q);
		cur  = VAL_W'(middle_q);
		next = VAL_W'(trace.sample);
		lo = (prev < cur) ? prev : cur;
		hi = (prev < cur) ? cur : prev;
		md = lo;
		if (lo >= next) begin
			md = lo;
			lo = next;
		end else if (hi >= next) begin
			md = next;
		end else begin
			md = hi;
			hi = next;
		end
		if (next < cur && prev < cur) begin
			srt = (lo + hi + VAL_W'(1)) >> 1;
			fin = hi;
		end else if (next > cur && prev > cur) begin
			srt = lo;
			fin = (lo + hi) >> 1;
		end else begin
			t   = (lo + md) >> 1;
			srt = (t >= VAL_W'(1)) ? t - VAL_W'(1) : t;
			t   = (md + hi) >> 1;
			fin = (t <= VAL_W'(TOP_ROW - 1)) ? t + VAL_W'(1) : t;
		end
		run_d = '{en: 1'b0, lo: srt, hi: fin};
		if (fin <= VAL_W'(TOP_ROW)) begin
			run_d.en = 1'b1;
			if (fin == VAL_W'(1) && prev == '0 && next == '0) begin
				run_d.hi = '0;
			end
		end else if (srt < VAL_W'(TOP_ROW) && srt > VAL_W'(MID_ROW)) begin
			run_d.en = 1'b1;
			run_d.hi = VAL_W'(TOP_ROW);
		end
	end

	// single dot for the first and last columns
	always_comb begin
		val_t q;
		q = VAL_W'(trace.sample) >> 3;
		if (q > VAL_W'(PAGE_LAST)) begin
			dot_page_d = '0;
			dot_byte_d = '0;
		end else begin
			dot_page_d = PAGE_W'(VAL_W'(PAGE_LAST) - q);
			dot_byte_d = pixbyte_t'(8'h80) >> trace.sample[2:0];
		end
	end

	// pixel byte of the current page
	always_comb begin
		val_t base, row;
		base = VAL_W'(8 * PAGE_LAST) - (VAL_W'(idx_s1) << 3);
		for (int b = 0; b < 8; b++) begin
			row = base + VAL_W'(b);
			page_bits[7 - b] = run_s1.en && row >= run_s1.lo && row <= run_s1.hi;
		end
	end

	assign inner_sel  = has_inner_s1 && (idx_s1 < IDX_W'(PAGES));
	assign cur_page   = inner_sel ? PAGE_W'(idx_s1) : dot_page_s1;
	assign cur_column = inner_sel ? COL_W'(cnt_s1 - CNT_W'(1)) : COL_W'(cnt_s1);
	assign cur_byte   = inner_sel ? page_bits : dot_byte_s1;
	assign cur_last   = inner_sel ? (idx_s1 == IDX_W'(PAGE_LAST) && !has_dot_s1) : 1'b1;

	assign advance     = job_valid_s1 && (!out_valid_q || pixels.ready);
	assign trace.ready = !job_valid_s1 || (advance && cur_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			older_q      <= '0;
			middle_q     <= '0;
			job_valid_s1 <= 1'b0;
			idx_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				cnt_q    <= last_col ? '0 : cnt_q + CNT_W'(1);
				older_q  <= middle_q;
				middle_q <= trace.sample;
			end
			if (in_acc && has_res) begin
				job_valid_s1 <= 1'b1;
				idx_s1       <= '0;
			end else if (advance) begin
				job_valid_s1 <= !cur_last;
				idx_s1       <= idx_s1 + IDX_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			has_inner_s1 <= has_inner;
			has_dot_s1   <= first_col || last_col;
			cnt_s1       <= cnt_q;
			run_s1       <= run_d;
			dot_page_s1  <= dot_page_d;
			dot_byte_s1  <= dot_byte_d;
		end
		if (advance) begin
			column_q <= cur_column;
			page_q   <= cur_page;
			byte_q   <= cur_byte;
			last_q   <= cur_last;
		end
	end

	assign pixels.valid      = out_valid_q;
	assign pixels.column     = column_q;
	assign pixels.page       = page_q;
	assign pixels.pixel_byte = byte_q;
	assign pixels.last       = last_q;

endmodule

>>> design/sctr_checker.sv
// ----------------------------------------------------------------------------
// sctr_checker
// Port-level checks of the trace column renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "scope_trace_column_render_macros.svh"

module sctr_checker import sctr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     trace_ready,
	input logic     pix_valid,
	input logic     pix_ready,
	input column_t  pix_column,
	input page_t    pix_page,
	input pixbyte_t pix_byte,
	input logic     pix_last
);

	logic beat;
	assign beat = pix_valid && pix_ready;

	// stalled beat holds
	`SCTR_ASSERT_NEXT(a_stall_hold, (pix_valid && !pix_ready),
		(pix_valid && $stable(pix_column) && $stable(pix_page) && $stable(pix_byte)
		&& $stable(pix_last)))

	// a busy input side means a beat is queued next cycle
	`SCTR_ASSERT_NEXT(a_busy_feeds_out, (!trace_ready), (pix_valid))

	// more beats of the same sample follow without a gap
	`SCTR_ASSERT_NEXT(a_no_gap, (beat && !pix_last), (pix_valid))

	// inner pages walk down one page at a time in the same column
	`SCTR_ASSERT_NEXT(a_page_walk, (beat && !pix_last && pix_page != PAGE_W'(PAGE_LAST)),
		(pix_page == PAGE_W'($past(pix_page) + PAGE_W'(1))
		&& pix_column == $past(pix_column)))

endmodule

bind scope_trace_column_render sctr_checker u_sctr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.trace_ready (trace.ready),
	.pix_valid   (pixels.valid),
	.pix_ready   (pixels.ready),
	.pix_column  (pixels.column),
	.pix_page    (pixels.page),
	.pix_byte    (pixels.pixel_byte),
	.pix_last    (pixels.last)
);

>>> tb/scope_trace_column_render_test.sv
// ----------------------------------------------------------------------------
// scope_trace_column_render_test
// Feeds trace samples through several frames, predicts every page pixel beat
// (dots on the first and last columns, runs on inner columns) and checks each
// beat in order. Both channels idle and stall at random in phases.
// ----------------------------------------------------------------------------
module scope_trace_column_render_test;
	import sctr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_SAMPLES = 390;

	typedef struct packed {
		column_t  column;
		page_t    page;
		pixbyte_t pixel_byte;
		logic     last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;

	sctr_trace_if trace_ch ();
	sctr_pixel_if pixel_ch ();

	scope_trace_column_render dut (
		.clk    (clk),
		.arst_n (arst_n),
		.trace  (trace_ch),
		.pixels (pixel_ch)
	);

	always #6 clk = ~clk;

	sample_t trace_samples[$];
	beat_t   pixel_expected[$];
	sample_t older_row;
	sample_t middle_row;
	int      next_column;
	int      samples_fed;
	int      mismatches;
	int      quiet_cycles;
	beat_t   want;

	function automatic int idle_percent(bit sender);
		int phase;
		phase = (samples_fed / 40) % 4;
		if (phase == 3)
			return 18;
		if (sender)
			return (phase == 1) ? 53 : 0;
		return (phase == 2) ? 53 : 0;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic beat_t dot_beat(int col, int v);
		beat_t b;
		b.column = column_t'(col);
		b.last = 1'b0;
		if (v / 8 > PAGE_LAST) begin
			b.page = '0;
			b.pixel_byte = '0;
		end else begin
			b.page = page_t'(PAGE_LAST - v / 8);
			b.pixel_byte = pixbyte_t'(8'h80 >> (v % 8));
		end
		return b;
	endfunction

	// expected beats for one accepted sample
	task automatic predict_column(sample_t s);
		beat_t    burst[8];
		pixbyte_t rows[8];
		int       k, c, prv, cur, nxt, lo, md, hi, run_lo, run_top, t, r;
		k = 0;
		c = next_column;
		prv = older_row;
		cur = middle_row;
		nxt = s;
		if (c == 0) begin
			burst[k] = dot_beat(0, nxt);
			k++;
		end else if (c >= 2) begin
			lo = (prv < cur) ? prv : cur;
			hi = (prv < cur) ? cur : prv;
			if (lo >= nxt) begin
				md = lo;
				lo = nxt;
			end else if (hi >= nxt) begin
				md = nxt;
			end else begin
				md = hi;
				hi = nxt;
			end
			if (nxt < cur && prv < cur) begin
				run_lo = (lo + hi + 1) / 2;
				run_top = hi;
			end else if (nxt > cur && prv > cur) begin
				run_lo = lo;
				run_top = (lo + hi) / 2;
			end else begin
				t = (lo + md) / 2;
				run_lo = (t >= 1) ? t - 1 : t;
				t = (md + hi) / 2;
				run_top = (t <= TOP_ROW - 1) ? t + 1 : t;
			end
			if (run_top <= TOP_ROW) begin
				if (run_top == 1 && prv == 0 && nxt == 0)
					run_top = 0;
			end else if (run_lo < TOP_ROW && run_lo > MID_ROW) begin
				run_top = TOP_ROW;
			end else begin
				run_top = -1;
			end
			foreach (rows[i])
				rows[i] = '0;
			for (r = run_lo; r <= run_top; r++)
				rows[(r / 8) % 8] |= pixbyte_t'(8'h80 >> (r % 8));
			for (int p = 0; p < PAGES; p++) begin
				burst[k].column = column_t'(c - 1);
				burst[k].page = page_t'(p);
				burst[k].pixel_byte = rows[(PAGE_LAST - p) % 8];
				burst[k].last = 1'b0;
				k++;
			end
		end
		if (c + 1 >= COLUMNS) begin
			if (c != 0) begin
				burst[k] = dot_beat(c, nxt);
				k++;
			end
			next_column = 0;
		end else begin
			next_column = c + 1;
		end
		older_row = middle_row;
		middle_row = s;
		if (k > 0)
			burst[k - 1].last = 1'b1;
		for (int i = 0; i < k; i++)
			pixel_expected.push_back(burst[i]);
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_ch.valid <= 1'b0;
			trace_ch.sample <= '0;
		end else begin
			if (trace_ch.valid && trace_ch.ready) begin
				predict_column(trace_ch.sample);
				samples_fed++;
			end
			if (!trace_ch.valid || trace_ch.ready) begin
				if (trace_samples.size() != 0 && !chance(idle_percent(1'b1))) begin
					trace_ch.valid <= 1'b1;
					trace_ch.sample <= trace_samples.pop_front();
				end else begin
					trace_ch.valid <= 1'b0;
				end
			end
		end
	end

	// pixel beat monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.ready <= 1'b0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				if (pixel_expected.size() == 0) begin
					$error("unexpected beat: column %0d page %0d pixel_byte %02h last %0b",
						pixel_ch.column, pixel_ch.page, pixel_ch.pixel_byte, pixel_ch.last);
					mismatches++;
				end else begin
					want = pixel_expected.pop_front();
					if (pixel_ch.column !== want.column) begin
						$error("column: expected %0d, got %0d", want.column, pixel_ch.column);
						mismatches++;
					end
					if (pixel_ch.page !== want.page) begin
						$error("page: expected %0d, got %0d", want.page, pixel_ch.page);
						mismatches++;
					end
					if (pixel_ch.pixel_byte !== want.pixel_byte) begin
						$error("pixel_byte: expected %02h, got %02h",
							want.pixel_byte, pixel_ch.pixel_byte);
						mismatches++;
					end
					if (pixel_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, pixel_ch.last);
						mismatches++;
					end
				end
			end
			pixel_ch.ready <= !chance(idle_percent(1'b0));
		end
	end

	always @(posedge clk) begin
		if ((trace_ch.valid && trace_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int walk, pick;
		sample_t corners[8];
		trace_ch.valid = 1'b0;
		trace_ch.sample = '0;
		pixel_ch.ready = 1'b0;
		older_row = '0;
		middle_row = '0;
		next_column = 0;
		samples_fed = 0;
		mismatches = 0;
		quiet_cycles = 0;
		corners = '{6'd0, 6'd1, 6'd28, 6'd29, 6'd54, 6'd55, 6'd56, 6'd63};

		// dot above top, flat floor, empty run, peaks, valleys, runs past the top
		trace_samples = '{6'd63, 6'd0, 6'd0, 6'd0, 6'd1, 6'd0, 6'd20, 6'd60, 6'd10,
			6'd0, 6'd56, 6'd0, 6'd50, 6'd40, 6'd30, 6'd5, 6'd10, 6'd15, 6'd63,
			6'd63, 6'd63, 6'd55, 6'd54, 6'd42, 6'd21};

		walk = 28;
		for (int i = 0; i < RANDOM_SAMPLES; i++) begin
			pick = $urandom_range(9);
			if (pick < 4) begin
				trace_samples.push_back(sample_t'($urandom_range(63)));
			end else if (pick < 8) begin
				walk = walk + $urandom_range(8) - 4;
				if (walk < 0)
					walk = 0;
				if (walk > 63)
					walk = 63;
				trace_samples.push_back(sample_t'(walk));
			end else begin
				trace_samples.push_back(corners[$urandom_range(7)]);
			end
		end

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (trace_samples.size() != 0 || trace_ch.valid || pixel_expected.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && pixel_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
